@@ hw/rtl/mp4_movie_duration_parser_macros.svh @@
// Assertion macros shared by the movie duration parser modules.
`ifndef MP4_MOVIE_DURATION_PARSER_MACROS_SVH
`define MP4_MOVIE_DURATION_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define MP4MD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define MP4MD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MP4MD_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define MP4MD_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hw/rtl/mp4md_pkg.sv @@
// Shared types and constants of the movie duration parser.
`default_nettype none

package mp4md_pkg;

    localparam int POSITION_WIDTH_DEF = 48;

    localparam logic [31:0] TAG_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] TAG_MVHD = 32'h6D766864;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic beat;
        logic clear_all;
        logic hdr_shift;
        logic cnt_clear;
        logic load_skip;
        logic skip_dec;
        logic load_limit;
        logic mvhd_step;
    } dp_cmd_t;

    // Status from the datapath, evaluated for the byte on the input.
    typedef struct packed {
        logic hdr_last;
        logic tag_moov;
        logic tag_mvhd;
        logic size_small;
        logic skip_zero;
        logic skip_end;
        logic moov_fits;
        logic sub_fits;
        logic mvhd_decide;
        logic found_ok;
    } dp_stat_t;

    // Request to produce the file's result.
    typedef struct packed {
        logic start;
        logic found;
    } emit_t;

endpackage

`default_nettype wire

@@ hw/rtl/mp4_movie_duration_parser.sv @@
// Top level of the movie duration parser: stream ports and unit wiring.
// Each input beat is parsed as it is taken; s_tready stays high while no result is pending.
// A miss is presented on m_tvalid in the cycle after the deciding beat.
// A hit passes through a constant multiply, a 74-step restoring division and rounding.
// Input is stalled from the deciding beat until the result beat is taken.
// Synchronous active-low reset returns the parser to the top-level box header.
`default_nettype none

module mp4_movie_duration_parser #(
    parameter int POSITION_WIDTH = mp4md_pkg::POSITION_WIDTH_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] data_byte
    input  wire          s_tlast,   // last_byte
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata,   // [31:0] timescale, [95:32] duration_ticks,
                                    // [127:96] duration_ms
    output logic         m_tuser    // found
);

    mp4md_pkg::dp_cmd_t  cmd;
    mp4md_pkg::dp_stat_t stat;
    mp4md_pkg::emit_t    emit;
    logic                beat;
    logic                busy;
    logic [31:0]         ts_step;
    logic [63:0]         dur_step;
    logic [31:0]         res_ts;
    logic [63:0]         res_dur;
    logic [31:0]         res_ms;

    assign s_tready = !busy;
    assign beat     = s_tvalid && s_tready;

    mp4md_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (beat),
        .last    (s_tlast),
        .stat    (stat),
        .cmd     (cmd),
        .emit_o  (emit)
    );

    mp4md_dpath #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_in (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .ts_out  (ts_step),
        .dur_out (dur_step)
    );

    mp4md_result u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .ts_in    (ts_step),
        .dur_in   (dur_step),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .found_o  (m_tuser),
        .ts_o     (res_ts),
        .dur_o    (res_dur),
        .ms_o     (res_ms)
    );

    assign m_tdata = {res_ms, res_dur, res_ts};

endmodule

`default_nettype wire

@@ hw/rtl/mp4md_result.sv @@
// Result unit: millisecond division, rounding, saturation and output register.
`default_nettype none
`include "mp4_movie_duration_parser_macros.svh"

module mp4md_result (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  var mp4md_pkg::emit_t  emit,
    input  wire  [31:0]           ts_in,
    input  wire  [63:0]           dur_in,
    output logic                  busy,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic                  found_o,
    output logic [31:0]           ts_o,
    output logic [63:0]           dur_o,
    output logic [31:0]           ms_o
);

    localparam int NUM_W = 74;
    localparam int BIT_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] MS_PER_SEC = NUM_W'(1000);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(NUM_W - 1);

    typedef enum logic [4:0] {
        RS_IDLE  = 5'b00001,
        RS_MUL   = 5'b00010,
        RS_DIV   = 5'b00100,
        RS_ROUND = 5'b01000,
        RS_HOLD  = 5'b10000
    } res_state_t;

    res_state_t       state_reg, state_next;
    logic             found_reg, found_next;
    logic [31:0]      ts_reg, ts_next;
    logic [63:0]      dur_reg, dur_next;
    logic [31:0]      ms_reg, ms_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [31:0]      rem_reg, rem_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             take;
    logic             round_up;
    logic             sat;

    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, ts_reg};
        take     = trial >= {1'b0, ts_reg};
        round_up = {rem_reg, 1'b0} >= {1'b0, ts_reg};
        sat      = (num_reg[NUM_W-1:32] != '0) || ((&num_reg[31:0]) && round_up);
    end

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        ts_next    = ts_reg;
        dur_next   = dur_reg;
        ms_next    = ms_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        case (state_reg)
            RS_IDLE: begin
                if (emit.start) begin
                    found_next = emit.found;
                    if (emit.found) begin
                        ts_next    = ts_in;
                        dur_next   = dur_in;
                        state_next = RS_MUL;
                    end else begin
                        ts_next    = '0;
                        dur_next   = '0;
                        ms_next    = '0;
                        state_next = RS_HOLD;
                    end
                end
            end
            RS_MUL: begin
                num_next   = NUM_W'(dur_reg) * MS_PER_SEC;
                rem_next   = '0;
                bit_next   = '0;
                state_next = RS_DIV;
            end
            RS_DIV: begin
                // Restoring division, one quotient bit per cycle; the quotient
                // shifts into the dividend register from the bottom.
                rem_next = take ? diff[31:0] : trial[31:0];
                num_next = {num_reg[NUM_W-2:0], take};
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_LAST) begin
                    state_next = RS_ROUND;
                end
            end
            RS_ROUND: begin
                ms_next    = sat ? '1 : (num_reg[31:0] + 32'(round_up));
                state_next = RS_HOLD;
            end
            RS_HOLD: begin
                if (m_tready) begin
                    state_next = RS_IDLE;
                end
            end
            default: begin
                state_next = RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        found_reg <= found_next;
        ts_reg    <= ts_next;
        dur_reg   <= dur_next;
        ms_reg    <= ms_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
    end

    assign busy     = (state_reg != RS_IDLE);
    assign m_tvalid = (state_reg == RS_HOLD);
    assign found_o  = found_reg;
    assign ts_o     = ts_reg;
    assign dur_o    = dur_reg;
    assign ms_o     = ms_reg;

    `MP4MD_ASSERT_IMP(a_start_when_idle, aclk, aresetn, emit.start, state_reg == RS_IDLE, "result requested while busy")
    `MP4MD_ASSERT_IMP(a_miss_is_zero, aclk, aresetn, m_tvalid && !found_reg, ts_reg == '0 && dur_reg == '0 && ms_reg == '0, "missing result carries nonzero fields")
    `MP4MD_ASSERT_NXT(a_div_ends, aclk, aresetn, state_reg == RS_DIV && bit_reg == BIT_LAST, state_reg == RS_ROUND, "division did not end after the last bit")

endmodule

`default_nettype wire

@@ hw/rtl/mp4md_dpath.sv @@
// Parser datapath: header shift register, counters, file position and mvhd fields.
`default_nettype none

module mp4md_dpath #(
    parameter int POSITION_WIDTH = mp4md_pkg::POSITION_WIDTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire  [7:0]              byte_in,
    input  var mp4md_pkg::dp_cmd_t  cmd,
    output mp4md_pkg::dp_stat_t     stat,
    output logic [31:0]             ts_out,
    output logic [63:0]             dur_out
);

    localparam int P   = POSITION_WIDTH;
    localparam int PW1 = POSITION_WIDTH + 1;
    localparam logic [5:0]  HDR_LAST_IDX = 6'd7;
    localparam logic [31:0] HDR_LEN      = 32'd8;
    localparam logic [5:0]  IDX_V0_TS    = 6'd12;
    localparam logic [5:0]  IDX_V0_DUR   = 6'd16;
    localparam logic [5:0]  IDX_V0_END   = 6'd19;
    localparam logic [5:0]  IDX_V1_TS    = 6'd20;
    localparam logic [5:0]  IDX_V1_DUR   = 6'd24;
    localparam logic [5:0]  IDX_V1_END   = 6'd31;

    logic [P-1:0]  pos_reg, pos_next, pos_inc;
    logic [P-1:0]  lim_reg, lim_next, lim_new, len_ext;
    logic [PW1-1:0] pos_plus8;
    logic [63:0]   hdr_reg, hdr_next, hdr_new;
    logic [5:0]    cnt_reg, cnt_next;
    logic [31:0]   skip_reg, skip_next;
    logic [7:0]    ver_reg, ver_next, ver_eff;
    logic [31:0]   ts_reg, ts_next, ts_step;
    logic [63:0]   dur_reg, dur_next, dur_step;
    logic [31:0]   box_size, box_body;
    logic          ver_zero, ts_shift, dur_shift;

    always_comb begin
        pos_inc   = pos_reg + P'(1);
        hdr_new   = {hdr_reg[55:0], byte_in};
        box_size  = hdr_new[63:32];
        box_body  = box_size - HDR_LEN;
        len_ext   = (box_size > HDR_LEN) ? P'(box_body) : '0;
        lim_new   = pos_inc + len_ext;
        pos_plus8 = {1'b0, pos_inc} + PW1'(8);

        ver_eff   = (cnt_reg == '0) ? byte_in : ver_reg;
        ver_zero  = (ver_eff == '0);
        ts_shift  = ver_zero ? (cnt_reg >= IDX_V0_TS && cnt_reg < IDX_V0_DUR)
                             : (cnt_reg >= IDX_V1_TS && cnt_reg < IDX_V1_DUR);
        dur_shift = ver_zero ? (cnt_reg >= IDX_V0_DUR && cnt_reg <= IDX_V0_END)
                             : (cnt_reg >= IDX_V1_DUR && cnt_reg <= IDX_V1_END);
        ts_step   = (cmd.mvhd_step && ts_shift) ? {ts_reg[23:0], byte_in} : ts_reg;
        dur_step  = (cmd.mvhd_step && dur_shift) ? {dur_reg[55:0], byte_in} : dur_reg;

        stat.hdr_last    = (cnt_reg == HDR_LAST_IDX);
        stat.tag_moov    = (hdr_new[31:0] == mp4md_pkg::TAG_MOOV);
        stat.tag_mvhd    = (hdr_new[31:0] == mp4md_pkg::TAG_MVHD);
        stat.size_small  = (box_size < HDR_LEN);
        stat.skip_zero   = (box_size == HDR_LEN);
        stat.skip_end    = (skip_reg == 32'd1);
        // A sub-box header fits when position + 8 does not pass the moov end.
        stat.moov_fits   = (lim_new >= P'(8)) && (pos_plus8 <= {1'b0, lim_new});
        stat.sub_fits    = (lim_reg >= P'(8)) && (pos_plus8 <= {1'b0, lim_reg});
        stat.mvhd_decide = ver_zero ? (cnt_reg == IDX_V0_END) : (cnt_reg == IDX_V1_END);
        stat.found_ok    = (ts_step != '0) && (dur_step != '0);
    end

    always_comb begin
        pos_next  = pos_reg;
        lim_next  = lim_reg;
        hdr_next  = hdr_reg;
        cnt_next  = cnt_reg;
        skip_next = skip_reg;
        ver_next  = ver_reg;
        ts_next   = ts_step;
        dur_next  = dur_step;
        if (cmd.clear_all) begin
            pos_next  = '0;
            lim_next  = '0;
            hdr_next  = '0;
            cnt_next  = '0;
            skip_next = '0;
            ver_next  = '0;
            ts_next   = '0;
            dur_next  = '0;
        end else begin
            if (cmd.beat) begin
                pos_next = pos_inc;
            end
            if (cmd.hdr_shift) begin
                hdr_next = hdr_new;
            end
            if (cmd.cnt_clear) begin
                cnt_next = '0;
            end else if (cmd.hdr_shift || cmd.mvhd_step) begin
                cnt_next = cnt_reg + 6'd1;
            end
            if (cmd.load_skip) begin
                skip_next = box_body;
            end else if (cmd.skip_dec) begin
                skip_next = skip_reg - 32'd1;
            end
            if (cmd.load_limit) begin
                lim_next = lim_new;
            end
            if (cmd.mvhd_step) begin
                ver_next = ver_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            lim_reg  <= '0;
            hdr_reg  <= '0;
            cnt_reg  <= '0;
            skip_reg <= '0;
            ver_reg  <= '0;
            ts_reg   <= '0;
            dur_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            lim_reg  <= lim_next;
            hdr_reg  <= hdr_next;
            cnt_reg  <= cnt_next;
            skip_reg <= skip_next;
            ver_reg  <= ver_next;
            ts_reg   <= ts_next;
            dur_reg  <= dur_next;
        end
    end

    assign ts_out  = ts_step;
    assign dur_out = dur_step;

endmodule

`default_nettype wire

@@ hw/rtl/mp4md_ctrl.sv @@
// Parser controller: box walk state machine driving the datapath.
`default_nettype none
`include "mp4_movie_duration_parser_macros.svh"

module mp4md_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      beat,
    input  wire                      last,
    input  var mp4md_pkg::dp_stat_t  stat,
    output mp4md_pkg::dp_cmd_t       cmd,
    output mp4md_pkg::emit_t         emit_o
);

    typedef enum logic [5:0] {
        PH_TOP_HDR  = 6'b000001,
        PH_TOP_SKIP = 6'b000010,
        PH_SUB_HDR  = 6'b000100,
        PH_SUB_SKIP = 6'b001000,
        PH_MVHD     = 6'b010000,
        PH_DONE     = 6'b100000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   is_top;

    always_comb begin
        phase_next    = phase_reg;
        cmd           = '0;
        emit_o        = '0;
        is_top        = (phase_reg == PH_TOP_HDR);
        if (beat) begin
            cmd.beat = 1'b1;
            case (phase_reg)
                PH_TOP_HDR, PH_SUB_HDR: begin
                    cmd.hdr_shift = 1'b1;
                    if (stat.hdr_last) begin
                        cmd.cnt_clear = 1'b1;
                        if (is_top && stat.tag_moov) begin
                            cmd.load_limit = 1'b1;
                            if (stat.moov_fits) begin
                                phase_next = PH_SUB_HDR;
                            end else begin
                                emit_o.start = 1'b1;
                            end
                        end else if (!is_top && stat.tag_mvhd) begin
                            phase_next = PH_MVHD;
                        end else if (stat.size_small) begin
                            emit_o.start = 1'b1;
                        end else begin
                            cmd.load_skip = 1'b1;
                            if (!stat.skip_zero) begin
                                phase_next = is_top ? PH_TOP_SKIP : PH_SUB_SKIP;
                            end else if (is_top) begin
                                phase_next = PH_TOP_HDR;
                            end else if (stat.sub_fits) begin
                                phase_next = PH_SUB_HDR;
                            end else begin
                                emit_o.start = 1'b1;
                            end
                        end
                    end
                end
                PH_TOP_SKIP: begin
                    cmd.skip_dec = 1'b1;
                    if (stat.skip_end) begin
                        phase_next = PH_TOP_HDR;
                    end
                end
                PH_SUB_SKIP: begin
                    cmd.skip_dec = 1'b1;
                    if (stat.skip_end) begin
                        cmd.cnt_clear = 1'b1;
                        if (stat.sub_fits) begin
                            phase_next = PH_SUB_HDR;
                        end else begin
                            emit_o.start = 1'b1;
                        end
                    end
                end
                PH_MVHD: begin
                    cmd.mvhd_step = 1'b1;
                    if (stat.mvhd_decide) begin
                        emit_o.start = 1'b1;
                        emit_o.found = stat.found_ok;
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_TOP_HDR;
                end
            endcase
            // The final byte of a file reports a miss if nothing was sent yet.
            if (last) begin
                if (!emit_o.start && phase_reg != PH_DONE) begin
                    emit_o.start = 1'b1;
                    emit_o.found = 1'b0;
                end
                cmd.clear_all = 1'b1;
                phase_next    = PH_TOP_HDR;
            end else if (emit_o.start) begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TOP_HDR;
        end else begin
            phase_reg <= phase_next;
        end
    end

    `MP4MD_ASSERT_IMP(a_done_is_quiet, aclk, aresetn, phase_reg == PH_DONE, !emit_o.start, "second result within one file")
    `MP4MD_ASSERT_NXT(a_emit_to_done, aclk, aresetn, emit_o.start && !cmd.clear_all, phase_reg == PH_DONE, "parser kept walking after its result")

endmodule

`default_nettype wire

@@ tb/mp4_duration_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts the movie duration result of each file from its beats and compares.
module mp4_duration_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [7:0]   s_tdata,
    input  wire          s_tlast,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [127:0] m_tdata,
    input  wire          m_tuser,
    output int           failures,
    output int           outstanding
);
    import mp4md_pkg::*;

    localparam int POS_W = POSITION_WIDTH_DEF;

    typedef enum logic [2:0] {
        SCAN_TOP_HDR,
        SCAN_TOP_SKIP,
        SCAN_SUB_HDR,
        SCAN_SUB_SKIP,
        SCAN_MVHD,
        SCAN_DONE
    } scan_e;

    typedef struct packed {
        logic        found;
        logic [31:0] time_scale;
        logic [63:0] ticks;
        logic [31:0] millis;
    } movie_info_t;

    movie_info_t expected_movies[$];

    scan_e            scan;
    logic [63:0]      hdr_shift;
    logic [5:0]       hdr_count;
    logic [31:0]      skip_left;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] moov_end;
    logic [7:0]       mvhd_ver;
    logic [31:0]      units;
    logic [63:0]      length;
    logic             reported;

    function automatic logic [31:0] to_millis(input logic [63:0] d, input logic [31:0] ts);
        logic [63:0] ts64, whole, rem, q, r;
        ts64  = {32'd0, ts};
        whole = d / ts64;
        rem   = d % ts64;
        if (whole > 64'd4294967) return 32'hFFFF_FFFF;
        q = whole * 64'd1000 + (rem * 64'd1000) / ts64;
        r = (rem * 64'd1000) % ts64;
        // Round half up on the remainder of the scaled fraction.
        if (2 * r >= ts64) q = q + 64'd1;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        return q[31:0];
    endfunction

    task automatic clear_parser();
        scan      = SCAN_TOP_HDR;
        hdr_shift = '0;
        hdr_count = '0;
        skip_left = '0;
        pos       = '0;
        moov_end  = '0;
        mvhd_ver  = '0;
        units     = '0;
        length    = '0;
        reported  = 1'b0;
    endtask

    task automatic report_movie(input logic ok);
        movie_info_t m;
        m = '0;
        if (ok && units != 0 && length != 0) begin
            m.found      = 1'b1;
            m.time_scale = units;
            m.ticks      = length;
            m.millis     = to_millis(length, units);
        end
        expected_movies.push_back(m);
        reported = 1'b1;
        scan     = SCAN_DONE;
    endtask

    // Next moov child is only parsed while its whole 8-byte header fits before the moov end.
    task automatic open_moov_child();
        if (moov_end >= 8 && pos <= moov_end - 8) begin
            scan      = SCAN_SUB_HDR;
            hdr_count = '0;
        end else begin
            report_movie(1'b0);
        end
    endtask

    task automatic close_header(input logic top);
        logic [31:0] size, tag;
        logic [63:0] body;
        size      = hdr_shift[63:32];
        tag       = hdr_shift[31:0];
        hdr_count = '0;
        if (top && tag == TAG_MOOV) begin
            body     = (size > 32'd8) ? {32'd0, size - 32'd8} : 64'd0;
            moov_end = pos + body[POS_W-1:0];
            open_moov_child();
        end else if (!top && tag == TAG_MVHD) begin
            scan = SCAN_MVHD;
        end else if (size < 32'd8) begin
            report_movie(1'b0);
        end else begin
            skip_left = size - 32'd8;
            if (skip_left != 0) scan = top ? SCAN_TOP_SKIP : SCAN_SUB_SKIP;
            else if (top) scan = SCAN_TOP_HDR;
            else open_moov_child();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [5:0] idx;
        pos = pos + 1'b1;
        case (scan)
            SCAN_TOP_HDR, SCAN_SUB_HDR: begin
                hdr_shift = {hdr_shift[55:0], b};
                hdr_count = hdr_count + 1'b1;
                if (hdr_count >= 6'd8) close_header(scan == SCAN_TOP_HDR);
            end
            SCAN_TOP_SKIP: begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0) scan = SCAN_TOP_HDR;
            end
            SCAN_SUB_SKIP: begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0) open_moov_child();
            end
            SCAN_MVHD: begin
                idx       = hdr_count;
                hdr_count = hdr_count + 1'b1;
                if (idx == 0) mvhd_ver = b;
                if (mvhd_ver == 8'd0) begin
                    if (idx >= 12 && idx <= 15) units = {units[23:0], b};
                    else if (idx >= 16 && idx <= 19) length = {length[55:0], b};
                    if (idx == 19) report_movie(1'b1);
                end else begin
                    if (idx >= 20 && idx <= 23) units = {units[23:0], b};
                    else if (idx >= 24 && idx <= 31) length = {length[55:0], b};
                    if (idx == 31) report_movie(1'b1);
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            if (!reported) report_movie(1'b0);
            clear_parser();
        end
    endtask

    task automatic flag_result(input string what, input movie_info_t want, input movie_info_t got);
        if (failures < 10) begin
            $display("%0t: %s: expected found=%0b ts=%0d ticks=%0d ms=%0d, got found=%0b ts=%0d ticks=%0d ms=%0d",
                     $time, what, want.found, want.time_scale, want.ticks, want.millis,
                     got.found, got.time_scale, got.ticks, got.millis);
        end
        failures++;
    endtask

    always @(posedge aclk) begin
        movie_info_t got, want;
        if (!aresetn) begin
            clear_parser();
            expected_movies.delete();
            outstanding <= 0;
        end else begin
            // A result can never belong to the beat taken at the same edge, so compare first.
            if (m_tvalid && m_tready) begin
                got.found      = m_tuser;
                got.time_scale = m_tdata[31:0];
                got.ticks      = m_tdata[95:32];
                got.millis     = m_tdata[127:96];
                if (expected_movies.size() == 0) begin
                    flag_result("result beat with no file pending", '0, got);
                end else begin
                    want = expected_movies.pop_front();
                    if (got.found !== want.found || got.time_scale !== want.time_scale ||
                        got.ticks !== want.ticks || got.millis !== want.millis) begin
                        flag_result("result mismatch", want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
            outstanding <= expected_movies.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the movie duration parser testbench: clock, reset, file stimulus and the verdict.
module tb;
    import mp4md_pkg::*;

    localparam int RUN_LIMIT = 400000;

    typedef enum int {
        FLAW_NONE,
        FLAW_TOP_SIZE,
        FLAW_SUB_SIZE,
        FLAW_SMALL_MOOV,
        FLAW_SHORT_MOOV,
        FLAW_NO_MOOV,
        FLAW_NOISE
    } file_flaw_e;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    logic hold_rx = 1'b0;
    logic hold_go = 1'b0;
    int   tx_idle_pct = 7;
    int   rx_idle_pct = 47;
    int   failures;
    int   outstanding;
    int   cycles = 0;
    int   beats_sent = 0;
    logic [7:0] file_q[$];

    always #5 aclk = ~aclk;

    mp4_movie_duration_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mp4_duration_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("** mp4_movie_duration_parser: FAILED **");
            $finish;
        end
    end

    // One long receiver stall so that a finished result backs up into the input.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    function automatic void put32(input logic [31:0] v);
        file_q.push_back(v[31:24]);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[7:0]);
    endfunction

    function automatic void put_filler(input int n);
        for (int i = 0; i < n; i++) file_q.push_back($urandom);
    endfunction

    // Random tag, or the other of moov and mvhd, never the one to avoid.
    function automatic logic [31:0] other_tag(input logic [31:0] avoid);
        logic [31:0] t;
        t = ($urandom_range(3) == 0) ? (TAG_MOOV ^ TAG_MVHD ^ avoid) : $urandom;
        return (t == avoid) ? ~t : t;
    endfunction

    function automatic int box_size();
        return 8 + (($urandom_range(24) == 0) ? $urandom_range(600) : $urandom_range(16));
    endfunction

    function automatic logic [31:0] rand_units();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1;
            3: return $urandom_range(1000, 1);
            4: return $urandom_range(96000, 600);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_length();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return '1;
            2: return {32'd0, $urandom};
            3: return {$urandom, $urandom};
            4: return {32'd0, $urandom_range(100000, 1)};
            default: return {22'd0, $urandom, 10'd0};
        endcase
    endfunction

    task automatic build_movie(input int n_boxes, input int n_kids, input logic [7:0] ver,
                               input logic [31:0] units, input logic [63:0] length,
                               input file_flaw_e flaw, input int tail);
        int kid_size[3];
        int body_len, moov_size, sz;
        file_q.delete();
        if (flaw == FLAW_NOISE) begin
            put_filler($urandom_range(40, 1));
            return;
        end
        if (flaw == FLAW_TOP_SIZE && n_boxes == 0) n_boxes = 1;
        if (flaw == FLAW_SUB_SIZE && n_kids == 0) n_kids = 1;
        for (int i = 0; i < n_boxes; i++) begin
            sz = (flaw == FLAW_TOP_SIZE && i == n_boxes - 1) ? $urandom_range(7) : box_size();
            put32(sz);
            put32(other_tag(TAG_MOOV));
            put_filler(sz - 8);
        end
        if (flaw != FLAW_NO_MOOV) begin
            body_len  = ((ver == 8'd0) ? 20 : 32) + $urandom_range(4);
            moov_size = 16 + body_len;
            for (int i = 0; i < n_kids; i++) begin
                kid_size[i] = (flaw == FLAW_SUB_SIZE && i == 0) ? $urandom_range(7)
                                                                : 8 + $urandom_range(16);
                moov_size += (kid_size[i] < 8) ? 8 : kid_size[i];
            end
            if (flaw == FLAW_SMALL_MOOV) moov_size = $urandom_range(8);
            if (flaw == FLAW_SHORT_MOOV) moov_size -= $urandom_range(body_len + 8, 1);
            put32(moov_size);
            put32(TAG_MOOV);
            for (int i = 0; i < n_kids; i++) begin
                put32(kid_size[i]);
                put32(other_tag(TAG_MVHD));
                put_filler(kid_size[i] - 8);
            end
            put32(8 + body_len);
            put32(TAG_MVHD);
            file_q.push_back(ver);
            put_filler(3);
            if (ver == 8'd0) begin
                put_filler(8);
                put32(units);
                put32(length[31:0]);
                put_filler(body_len - 20);
            end else begin
                put_filler(16);
                put32(units);
                put32(length[63:32]);
                put32(length[31:0]);
                put_filler(body_len - 32);
            end
        end
        put_filler(tail);
    endtask

    task automatic cut_file(input int keep);
        while (file_q.size() > keep) file_q.delete(file_q.size() - 1);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= file_q[i];
            s_tlast  <= (i == file_q.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            beats_sent++;
        end
    endtask

    initial begin
        int n_files;
        int pick;
        logic [7:0] ver;
        file_flaw_e flaw;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A single-beat file can only end truncated.
        file_q.delete();
        file_q.push_back(8'hA5);
        send_file();
        // Size codes zero and one are both treated as a box too small to hold its header.
        file_q.delete();
        put32(0);
        put32(other_tag(TAG_MOOV));
        put_filler(3);
        send_file();
        file_q.delete();
        put32(1);
        put32(other_tag(TAG_MOOV));
        put_filler(2);
        send_file();
        // Largest box size, cut short by the last beat.
        file_q.delete();
        put32('1);
        put32('1);
        put_filler(9);
        send_file();
        // A moov holding nothing but its own header.
        file_q.delete();
        put32(8);
        put32(TAG_MOOV);
        put_filler(12);
        send_file();

        build_movie(0, 0, 8'd0, 32'd1000, 64'd5000, FLAW_NONE, 0);
        send_file();
        build_movie(1, 1, 8'd1, '1, '1, FLAW_NONE, 3);
        send_file();
        build_movie(0, 0, 8'd0, 32'd0, 64'd77, FLAW_NONE, 2);
        send_file();
        build_movie(0, 1, 8'd0, 32'd600, 64'd0, FLAW_NONE, 0);
        send_file();
        build_movie(0, 0, 8'hFF, 32'd3, 64'd2, FLAW_NONE, 0);
        send_file();
        build_movie(0, 0, 8'h80, 32'd2000, 64'd1, FLAW_NONE, 0);
        send_file();
        build_movie(0, 0, 8'd0, 32'd1, 64'hFFFF_FFFF, FLAW_NONE, 1);
        send_file();
        build_movie(0, 1, 8'd1, 32'd90000, 64'd123456789, FLAW_SHORT_MOOV, 0);
        send_file();
        build_movie(0, 1, 8'd0, 32'd48000, 64'd480000, FLAW_SUB_SIZE, 2);
        send_file();
        build_movie(2, 0, 8'd0, 32'd1000, 64'd1, FLAW_NO_MOOV, 4);
        send_file();
        build_movie(1, 0, 8'd0, 32'd1000, 64'd1, FLAW_TOP_SIZE, 0);
        send_file();
        build_movie(0, 0, 8'd1, 32'd44100, 64'd441000, FLAW_NONE, 0);
        cut_file(30);
        send_file();
        build_movie(0, 0, 8'd0, 32'd25, 64'd100, FLAW_SMALL_MOOV, 3);
        send_file();
        build_movie(0, 0, 8'd0, 32'd0, 64'd0, FLAW_NOISE, 0);
        send_file();

        // Mostly well-formed files with random content, the rest broken or noise.
        hold_go = 1'b1;
        n_files = 0;
        while (beats_sent < 1050 || n_files < 40) begin
            if (n_files == 14) begin
                tx_idle_pct = 47;
                rx_idle_pct = 7;
            end
            if (n_files == 28) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(99);
            ver  = $urandom_range(255, 1);
            if ($urandom_range(1)) ver = 8'd0;
            else if ($urandom_range(1)) ver = 8'd1;
            flaw = (pick < 70) ? FLAW_NONE : file_flaw_e'($urandom_range(6, 1));
            build_movie($urandom_range(2), $urandom_range(2), ver, rand_units(), rand_length(),
                        flaw, $urandom_range(6));
            if (pick >= 60 && pick < 72) cut_file($urandom_range(file_q.size(), 1));
            send_file();
            n_files++;
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (failures == 0) begin
            $display("** mp4_movie_duration_parser: PASSED **");
        end else begin
            $display("** mp4_movie_duration_parser: FAILED **");
        end
        $finish;
    end

endmodule
